[rtl/core/dqc_pkg.sv]
package dqc_pkg;

   localparam int WORD_W        = 32;
   localparam int OCC_W         = 5;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_DUMP       = 3'd4
   } op_type;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [WORD_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] value_out;
      logic                     last_of_run;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic write_pos;
      logic rotate;
   } cell_cmd_type;

endpackage

[rtl/core/dqc_cell.sv]
module dqc_cell #(
   parameter int DEPTH = 16,
   parameter int IDX   = 0
) (
   input  logic                             clock,
   input  dqc_pkg::cell_cmd_type            cmd,
   input  logic [$clog2(DEPTH+1)-1:0]       pos,
   input  logic [dqc_pkg::WORD_W-1:0]       value,
   input  logic [dqc_pkg::WORD_W-1:0]       prev_data,
   input  logic [dqc_pkg::WORD_W-1:0]       next_data,
   input  logic [dqc_pkg::WORD_W-1:0]       head_data,
   output logic [dqc_pkg::WORD_W-1:0]       data_out
);
   import dqc_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic              hit;

   assign hit = (pos == CW'(IDX));

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_right) begin
         data_in = prev_data;
      end else if (cmd.shift_left) begin
         data_in = next_data;
      end else if (cmd.write_pos) begin
         if (hit) begin
            data_in = value;
         end
      end else if (cmd.rotate) begin
         data_in = hit ? head_data : next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

[rtl/core/dqc_chain.sv]
module dqc_chain #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  dqc_pkg::cell_cmd_type            cmd,
   input  logic [$clog2(DEPTH+1)-1:0]       pos,
   input  logic [dqc_pkg::WORD_W-1:0]       value,
   output logic [dqc_pkg::WORD_W-1:0]       head
);
   import dqc_pkg::*;

   logic [WORD_W-1:0] data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] prev_w;
      logic [WORD_W-1:0] next_w;

      if (i == 0) begin : g_first
         assign prev_w = value;
      end else begin : g_mid_prev
         assign prev_w = data[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign next_w = data[i];
      end else begin : g_mid_next
         assign next_w = data[i+1];
      end

      dqc_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .pos       (pos),
         .value     (value),
         .prev_data (prev_w),
         .next_data (next_w),
         .head_data (data[0]),
         .data_out  (data[i])
      );
   end

   assign head = data[0];

endmodule

[rtl/core/double_ended_queue_top.sv]
// Push, pop: result registered for the next cycle; one item per cycle unless stalled.
// Dump of n words: n beats, one per cycle if not stalled; input held off until the last.
// Two cell rows hold the words front-first and rear-first; dump rotates the front row.
// Reset clears the fill count, the state and the result valid; the cell rows are not
// cleared, since a word is only read after it was written.
module double_ended_queue_top #(
   parameter int DEPTH = dqc_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dqc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dqc_pkg::rsp_type rsp_data
);
   import dqc_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   state_type    state_ff;
   state_type    state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] dump_left_ff;
   logic [CW-1:0] dump_left_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;
   logic          load;

   cell_cmd_type      fcmd;
   cell_cmd_type      rcmd;
   logic [CW-1:0]     fpos;
   logic [CW-1:0]     rpos;
   logic [WORD_W-1:0] front_head;
   logic [WORD_W-1:0] rear_head;

   logic out_free;
   logic accept;
   logic full;
   logic empty;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   dqc_chain #(.DEPTH(DEPTH)) u_front (
      .clock (clock),
      .cmd   (fcmd),
      .pos   (fpos),
      .value (req_data.value_in),
      .head  (front_head)
   );

   dqc_chain #(.DEPTH(DEPTH)) u_rear (
      .clock (clock),
      .cmd   (rcmd),
      .pos   (rpos),
      .value (req_data.value_in),
      .head  (rear_head)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.op == OP_DUMP) && !empty && (count_ff != CW'(1))) begin
               state_in = S_DUMP;
            end
         end
         S_DUMP: begin
            if (out_free && (dump_left_ff == CW'(1))) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      fcmd         = '0;
      rcmd         = '0;
      fpos         = count_ff;
      rpos         = count_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      load         = 1'b0;
      rsp_data_in             = '0;
      rsp_data_in.status      = STAT_OK;
      rsp_data_in.last_of_run = 1'b1;
      rsp_data_in.occupancy   = OCC_W'(count_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load = 1'b1;
               case (req_data.op)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        rsp_data_in.status = STAT_FULL;
                     end else begin
                        fcmd.shift_right = 1'b1;
                        rcmd.write_pos   = 1'b1;
                        count_in         = count_ff + CW'(1);
                        rsp_data_in.occupancy = OCC_W'(count_ff + CW'(1));
                     end
                  end
                  OP_PUSH_REAR: begin
                     if (full) begin
                        rsp_data_in.status = STAT_FULL;
                     end else begin
                        fcmd.write_pos   = 1'b1;
                        rcmd.shift_right = 1'b1;
                        count_in         = count_ff + CW'(1);
                        rsp_data_in.occupancy = OCC_W'(count_ff + CW'(1));
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        rsp_data_in.status = STAT_EMPTY;
                     end else begin
                        fcmd.shift_left       = 1'b1;
                        count_in              = count_ff - CW'(1);
                        rsp_data_in.value_out = front_head;
                        rsp_data_in.occupancy = OCC_W'(count_ff - CW'(1));
                     end
                  end
                  OP_POP_REAR: begin
                     if (empty) begin
                        rsp_data_in.status = STAT_EMPTY;
                     end else begin
                        rcmd.shift_left       = 1'b1;
                        count_in              = count_ff - CW'(1);
                        rsp_data_in.value_out = rear_head;
                        rsp_data_in.occupancy = OCC_W'(count_ff - CW'(1));
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        rsp_data_in.status = STAT_EMPTY;
                     end else begin
                        fcmd.rotate             = 1'b1;
                        fpos                    = count_ff - CW'(1);
                        dump_left_in            = count_ff - CW'(1);
                        rsp_data_in.value_out   = front_head;
                        rsp_data_in.last_of_run = (count_ff == CW'(1));
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               load                    = 1'b1;
               fcmd.rotate             = 1'b1;
               fpos                    = count_ff - CW'(1);
               dump_left_in            = dump_left_ff - CW'(1);
               rsp_data_in.value_out   = front_head;
               rsp_data_in.last_of_run = (dump_left_ff == CW'(1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
